// ===== hw/rtl/acmac_pkg.sv =====
package acmac_pkg;
  localparam int BLOCK_BYTES = 16;
  localparam int BLOCK_W = 8 * BLOCK_BYTES;
  localparam int KEY_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int VB_W = 5;
  localparam int FIFO_DEPTH = 2;
  localparam logic [7:0] RB_CONST = 8'h87;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 3'd0, REG_KEY1 = 3'd1, REG_KEY2 = 3'd2, REG_KEY3 = 3'd3, REG_KLEN = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_SUBKEY, ST_BLOCK
  } back_state_t;

  // One queued message block, already classified by the front part.
  typedef struct packed {
    logic [BLOCK_W-1:0] data;
    logic               last;
    logic               full;
  } blk_t;

  localparam int BLK_W = BLOCK_W + 2;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
  // Byte i of the state sits at bits [127-8i -: 8].
  function automatic logic [BLOCK_W-1:0] aes_round(input logic [BLOCK_W-1:0] s,
                                                    input logic [BLOCK_W-1:0] rk,
                                                    input logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4*c+r] = b[4*((c+r)%4)+r];
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o ^ rk;
  endfunction

  function automatic logic [BLOCK_W-1:0] dbl(input logic [BLOCK_W-1:0] v);
    return {v[BLOCK_W-2:0], 1'b0} ^ {{(BLOCK_W-8){1'b0}}, (v[BLOCK_W-1] ? RB_CONST : 8'h00)};
  endfunction
endpackage

// ===== hw/rtl/acmac_stream_if.sv =====
interface acmac_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/acmac_in_if.sv =====
interface acmac_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic [4:0]  valid_bytes;
  logic        last;
  modport source (output valid, output block_hi, output block_lo, output valid_bytes,
                  output last, input ready);
  modport sink (input valid, input block_hi, input block_lo, input valid_bytes,
                input last, output ready);
endinterface

// ===== hw/rtl/acmac_out_if.sv =====
interface acmac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_hi;
  logic [63:0] tag_lo;
  modport source (output valid, output tag_hi, output tag_lo, input ready);
  modport sink (input valid, input tag_hi, input tag_lo, output ready);
endinterface

// ===== hw/rtl/aes_cmac_tag_engine.sv =====
// AES-CMAC tag engine.
// in_*: one 16-byte message block per item (block_hi/block_lo, valid_bytes,
// last), valid/ready handshake. out_*: one 16-byte tag per last block.
// cfg_*: write-only port for the key words (index 0..3) and key length (4);
// write only while idle. A write to index 0..4 makes the subkeys be derived again.
// A front stage pads partial last blocks and pushes items into a queue (two
// entries by default); the back stage runs one AES round per cycle.
// Each block runs Nr rounds (10, 12 or 14 for 128, 192, 256-bit keys)
// after a launch step from the queue; the round loop sets the rate. The
// first block after reset or a key write waits for the subkey derivation.
// A tag appears in the cycle after its last round.
// Reset clears the queue, chaining value and subkey-ready flag.
// If the receiver stalls, the tag is held and the engine finishes the
// current block; it launches no new block while a tag is waiting.
module aes_cmac_tag_engine import acmac_pkg::*; #(
  parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  acmac_in_if.sink             in_ch,
  acmac_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_wdata
);
  logic [KEY_W-1:0] key0_r, key1_r, key2_r, key3_r;
  logic [1:0]       klen_r;
  logic             kwr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0; key1_r <= '0; key2_r <= '0; key3_r <= '0; klen_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0: key0_r <= cfg_wdata;
        REG_KEY1: key1_r <= cfg_wdata;
        REG_KEY2: key2_r <= cfg_wdata;
        REG_KEY3: key3_r <= cfg_wdata;
        REG_KLEN: klen_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end
  assign kwr = cfg_we && (cfg_index <= REG_KLEN);

  acmac_stream_if #(.W(BLK_W)) q_in ();
  acmac_stream_if #(.W(BLK_W)) q_out ();

  acmac_front u_front (.in_ch(in_ch), .q_in(q_in));
  acmac_fifo #(.W(BLK_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .s(q_in), .m(q_out));
  acmac_back u_back (
    .clk(clk), .rst_n(rst_n), .key({key0_r, key1_r, key2_r, key3_r}),
    .key_len(klen_r), .key_write(kwr), .q_out(q_out), .out_ch(out_ch));
endmodule

// ===== hw/rtl/acmac_front.sv =====
module acmac_front import acmac_pkg::*; (
  acmac_in_if.sink           in_ch,
  acmac_stream_if.source     q_in
);
  // Last blocks that are partial get their padding here; the back part only
  // needs to know which subkey applies.
  logic [BLOCK_W-1:0] raw, padded;
  logic               full;

  assign raw  = {in_ch.block_hi, in_ch.block_lo};
  assign full = in_ch.valid_bytes >= VB_W'(BLOCK_BYTES);

  always_comb begin
    padded = raw;
    if (in_ch.last && !full) begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        if (i == int'(in_ch.valid_bytes)) padded[BLOCK_W-1-8*i -: 8] = PAD_BYTE;
        else if (i > int'(in_ch.valid_bytes)) padded[BLOCK_W-1-8*i -: 8] = 8'h00;
      end
    end
  end

  blk_t blk;
  always_comb begin
    blk.data = padded;
    blk.last = in_ch.last;
    blk.full = full;
  end

  assign q_in.valid  = in_ch.valid;
  assign q_in.data   = blk;
  assign in_ch.ready = q_in.ready;
endmodule

// ===== hw/rtl/acmac_fifo.sv =====
module acmac_fifo import acmac_pkg::*; #(
  parameter int W = BLK_W,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  acmac_stream_if.sink    s,
  acmac_stream_if.source  m
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  wire push = s.valid && s.ready;
  wire pop  = m.valid && m.ready;

  assign s.ready = cnt_r != (AW+1)'(DEPTH);
  assign m.valid = cnt_r != '0;
  assign m.data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= s.data;
  end
endmodule

// ===== hw/rtl/acmac_back.sv =====
module acmac_back import acmac_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [4*KEY_W-1:0] key,
  input  logic [1:0]       key_len,
  input  logic             key_write,
  acmac_stream_if.sink     q_out,
  acmac_out_if.source      out_ch
);
  back_state_t state_r, state_nxt;
  logic [BLOCK_W-1:0] st_r, chain_r, k1_r, k2_r;
  logic [255:0]       kw_r;   // sliding key-schedule window, newest words low
  logic [3:0]         rnd_r;
  logic [2:0]         kcnt_r; // position inside an nk-word group
  logic [3:0]         rc_r;
  logic               ready_r, last_r;
  logic               ov_r;
  logic [BLOCK_W-1:0] ores_r;
  blk_t               b;

  logic [3:0] nr;
  logic [2:0] nk_sel;
  assign nk_sel = (key_len == 2'd0) ? 3'd0 : (key_len == 2'd1) ? 3'd1 : 3'd2;
  assign nr = (nk_sel == 3'd0) ? 4'd10 : (nk_sel == 3'd1) ? 4'd12 : 4'd14;

  assign b = blk_t'(q_out.data);

  // Round keys are produced four words a cycle by running the schedule
  // forward; word i depends on words i-1 and i-nk.
  function automatic logic [31:0] rcon_f(input logic [3:0] i);
    unique case (i)
      4'd1: return 32'h01000000; 4'd2: return 32'h02000000;
      4'd3: return 32'h04000000; 4'd4: return 32'h08000000;
      4'd5: return 32'h10000000; 4'd6: return 32'h20000000;
      4'd7: return 32'h40000000; 4'd8: return 32'h80000000;
      4'd9: return 32'h1b000000; 4'd10: return 32'h36000000;
      default: return 32'h0;
    endcase
  endfunction

  logic [31:0] w [12];   // w[0..7] history (w[7] newest), w[8..11] new words
  logic [2:0]  kc [5];
  logic [3:0]  rc [5];
  logic [3:0]  nkv;
  logic [31:0] t;
  always_comb begin
    nkv = 4'd4 + {nk_sel[1:0], 1'b0};
    for (int i = 0; i < 8; i++) w[i] = kw_r[255-32*i -: 32];
    kc[0] = kcnt_r; rc[0] = rc_r;
    for (int j = 0; j < 4; j++) begin
      t = w[7+j];
      if (kc[j] == 3'd0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ rcon_f(rc[j]);
      end else if (nk_sel == 3'd2 && kc[j] == 3'd4) begin
        t = sub_word(t);
      end
      w[8+j] = w[8+j-int'(nkv)] ^ t;
      kc[j+1] = (kc[j] == 3'(nkv - 4'd1)) ? 3'd0 : kc[j] + 3'd1;
      rc[j+1] = (kc[j] == 3'(nkv - 4'd1)) ? rc[j] + 4'd1 : rc[j];
    end
  end
  logic [BLOCK_W-1:0] rk_next;
  assign rk_next = {w[8], w[9], w[10], w[11]};

  // Initial window: key words at the end of the window, so round key 0 is
  // the first four key words.
  logic [255:0] kw_init;
  logic [2:0]   kc_init;
  logic [BLOCK_W-1:0] rk0;
  always_comb begin
    unique case (nk_sel)
      3'd0: kw_init = {128'h0, key[255:128]};
      3'd1: kw_init = {64'h0, key[255:64]};
      default: kw_init = key;
    endcase
    kc_init = 3'd0;  // the first computed word, word nk, opens a new group
    rk0 = key[255:128];
  end

  // Round key 1 takes key words past the first four before schedule words.
  logic [BLOCK_W-1:0] rk_use;
  logic [255:0]       kw_adv;
  logic               use_key;
  always_comb begin
    use_key = (nk_sel != 3'd0) && (rnd_r == 4'd0);
    if (nk_sel == 3'd2 && rnd_r == 4'd0) begin
      rk_use = key[127:0];
      kw_adv = kw_r;
    end else if (nk_sel == 3'd1 && rnd_r == 4'd0) begin
      rk_use = {key[127:64], w[8], w[9]};
      kw_adv = {kw_r[191:0], w[8], w[9]};
    end else begin
      rk_use = rk_next;
      kw_adv = {kw_r[127:0], rk_next};
    end
  end

  logic [BLOCK_W-1:0] rnd_out;
  assign rnd_out = aes_round(st_r, rk_use, rnd_r != nr - 4'd1);

  logic start_sub, start_blk, done;
  logic [BLOCK_W-1:0] blk_in;
  assign blk_in = chain_r ^ b.data ^ (b.last ? (b.full ? k1_r : k2_r) : '0);
  assign done = (state_r == ST_SUBKEY || state_r == ST_BLOCK) && rnd_r == nr - 4'd1;

  logic out_free;
  assign out_free = !ov_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_out.valid && !ready_r) state_nxt = ST_SUBKEY;
        else if (q_out.valid && out_free) state_nxt = ST_BLOCK;
      end
      ST_SUBKEY: if (done) state_nxt = ST_IDLE;
      ST_BLOCK: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    start_sub = state_r == ST_IDLE && q_out.valid && !ready_r;
    start_blk = state_r == ST_IDLE && q_out.valid && ready_r && out_free;
    q_out.ready = start_blk;
  end

  logic [BLOCK_W-1:0] l1;
  assign l1 = dbl(rnd_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b0;
      ov_r    <= 1'b0;
      chain_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (key_write) ready_r <= 1'b0;
      else if (done && state_r == ST_SUBKEY) ready_r <= 1'b1;
      if (done && state_r == ST_BLOCK) begin
        if (last_r) begin
          chain_r <= '0;
          ov_r    <= 1'b1;
        end else begin
          chain_r <= rnd_out;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_sub || start_blk) begin
      st_r   <= (start_sub ? '0 : blk_in) ^ rk0;
      kw_r   <= kw_init;
      kcnt_r <= kc_init;
      rc_r   <= 4'd1;
      rnd_r  <= 4'd0;
      last_r <= b.last;
    end else if (state_r != ST_IDLE) begin
      st_r  <= rnd_out;
      rnd_r <= rnd_r + 4'd1;
      kw_r  <= kw_adv;
      if (!(use_key && nk_sel == 3'd2)) begin
        kcnt_r <= (nk_sel == 3'd1 && use_key) ? kc[2] : kc[4];
        rc_r   <= (nk_sel == 3'd1 && use_key) ? rc[2] : rc[4];
      end
    end
    if (done && state_r == ST_SUBKEY) begin
      k1_r <= l1;
      k2_r <= dbl(l1);
    end
    if (done && state_r == ST_BLOCK && last_r) ores_r <= rnd_out;
  end

  assign out_ch.valid  = ov_r;
  assign out_ch.tag_hi = ores_r[127:64];
  assign out_ch.tag_lo = ores_r[63:0];
endmodule

// ===== hw/rtl/acmac_checker.sv =====
module acmac_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] tag_hi,
  input logic [63:0] tag_lo
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tag_hi) && $stable(tag_lo))
    else $error("tag changed while stalled");
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("tag valid after reset");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before it was taken");
endmodule

bind aes_cmac_tag_engine acmac_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .tag_hi(out_ch.tag_hi), .tag_lo(out_ch.tag_lo));
